@@ rtl/ssb_pkg.sv @@
package ssb_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CNT_W   = 5;
	localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(WORD_W - 1);

	// x / 10 == (x * RECIP10) >> 19, exact for every x below 2^16
	localparam logic [16:0] RECIP10 = 17'h0CCCD;
	localparam int unsigned RECIP_SH = 19;

	localparam logic [3:0] BAR_MAX = 4'd8;

	localparam logic [7:0] DOT_HUNDREDS = 8'd1;
	localparam logic [7:0] DOT_TENS     = 8'd2;
	localparam logic [7:0] DOT_UNITS    = 8'd3;

	localparam int unsigned DOT_HUNDREDS_BIT = 16;
	localparam int unsigned DOT_TENS_BIT     = 11;
	localparam int unsigned DOT_UNITS_BIT    = 0;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// pattern PCDE--------GFAB, used by hundreds (upper half) and units
	function automatic logic [15:0] outer_seg(input logic [3:0] d);
		logic [15:0] p;
		case (d)
			4'd0: p = 16'h7007;
			4'd1: p = 16'h4001;
			4'd2: p = 16'h300B;
			4'd3: p = 16'h600B;
			4'd4: p = 16'h400D;
			4'd5: p = 16'h600E;
			4'd6: p = 16'h700E;
			4'd7: p = 16'h4003;
			4'd8: p = 16'h700F;
			4'd9: p = 16'h600F;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

	// pattern ----PCDEGFAB----, used by tens
	function automatic logic [15:0] middle_seg(input logic [3:0] d);
		logic [15:0] p;
		case (d)
			4'd0: p = 16'h0770;
			4'd1: p = 16'h0410;
			4'd2: p = 16'h03B0;
			4'd3: p = 16'h06B0;
			4'd4: p = 16'h04D0;
			4'd5: p = 16'h06E0;
			4'd6: p = 16'h07E0;
			4'd7: p = 16'h0430;
			4'd8: p = 16'h07F0;
			4'd9: p = 16'h06F0;
			default: p = 16'h0000;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/ssb_front.sv @@
module ssb_front import ssb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [15:0] number,
	input  logic [7:0]  bar_level,
	input  logic [7:0]  dot_choice,
	input  q_status_t qstat,
	output logic      push,
	output word_t     push_word
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic advance;

	logic [15:0] n_s1, n_s2;
	logic [7:0]  bar_s1, dot_s1;
	word_t       ext_s2, ext_s3, ext_s4;
	logic [12:0] q1_s2, q1_s3;
	logic [3:0]  units_s3, units_s4;
	logic [9:0]  q2_s3, q2_s4;
	logic [3:0]  tens_s4;
	logic [6:0]  q3_s4;
	word_t       word_s5;

	logic [32:0] prod1;
	logic [29:0] prod2;
	logic [26:0] prod3;
	logic [15:0] units_full;
	logic [12:0] tens_full;
	logic [9:0]  hund_full;
	logic [3:0]  bar_clamp;
	logic [7:0]  therm;
	word_t       ext_c;
	word_t       word_c;

	// hold the whole pipe while the finished word cannot enter the queue
	assign advance  = !v_s5 || !qstat.full;
	assign in_ready = advance;
	assign push      = v_s5 && !qstat.full;
	assign push_word = word_s5;

	always_comb begin
		prod1 = 33'(n_s1) * 33'(RECIP10);
		prod2 = 30'(q1_s2) * 30'(RECIP10);
		prod3 = 27'(q2_s3) * 27'(RECIP10);
		units_full = n_s2 - 16'(q1_s2) * 16'd10;
		tens_full  = q1_s3 - 13'(q2_s3) * 13'd10;
		hund_full  = q2_s4 - 10'(q3_s4) * 10'd10;

		bar_clamp = (bar_s1 > 8'(BAR_MAX)) ? BAR_MAX : bar_s1[3:0];
		for (int i = 0; i < 8; i++) begin
			therm[i] = (4'(i) < bar_clamp);
		end
		ext_c = '0;
		ext_c[27:24] = therm[3:0];
		ext_c[23] = therm[4];
		ext_c[22] = therm[5];
		ext_c[21] = therm[6];
		ext_c[20] = therm[7];
		case (dot_s1)
			DOT_HUNDREDS: ext_c[DOT_HUNDREDS_BIT] = 1'b1;
			DOT_TENS:     ext_c[DOT_TENS_BIT] = 1'b1;
			DOT_UNITS:    ext_c[DOT_UNITS_BIT] = 1'b1;
			default:      ;
		endcase

		word_c = {outer_seg(hund_full[3:0]), 16'h0000}
			| {16'h0000, middle_seg(tens_s4)}
			| {16'h0000, outer_seg(units_s4)}
			| ext_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			n_s1     <= number;
			bar_s1   <= bar_level;
			dot_s1   <= dot_choice;
			n_s2     <= n_s1;
			q1_s2    <= prod1[31:RECIP_SH];
			ext_s2   <= ext_c;
			q1_s3    <= q1_s2;
			q2_s3    <= prod2[28:RECIP_SH];
			units_s3 <= units_full[3:0];
			ext_s3   <= ext_s2;
			q2_s4    <= q2_s3;
			q3_s4    <= prod3[25:RECIP_SH];
			tens_s4  <= tens_full[3:0];
			units_s4 <= units_s3;
			ext_s4   <= ext_s3;
			word_s5  <= word_c;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && qstat.full) |=> (v_s5 && $stable(word_s5)))
		else $error("front: stalled word changed");

endmodule

@@ rtl/ssb_fifo.sv @@
module ssb_fifo import ssb_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  word_t     push_word,
	input  logic      pop,
	output word_t     pop_word,
	output q_status_t qstat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	word_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign pop_word    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("fifo: push while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("fifo: pop while empty");

endmodule

@@ rtl/ssb_back.sv @@
module ssb_back import ssb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t qstat,
	output logic      pop,
	input  word_t     pop_word,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      serial_bit,
	output logic      latch_after
);

	word_t            sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             xfer;

	assign xfer        = busy_q && out_ready;
	// load the next word right behind the last bit of the current one
	assign pop         = !qstat.empty && (!busy_q || (xfer && cnt_q == BIT_LAST));
	assign out_valid   = busy_q;
	assign serial_bit  = sh_q[0];
	assign latch_after = (cnt_q == BIT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (xfer) begin
			if (cnt_q == BIT_LAST) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= pop_word;
		end else if (xfer) begin
			sh_q <= {1'b0, sh_q[WORD_W-1:1]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && cnt_q != BIT_LAST) |=> (busy_q && cnt_q == $past(cnt_q) + 1'b1))
		else $error("back: word cut short");

	assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && cnt_q != BIT_LAST) |=> (serial_bit == $past(sh_q[1])))
		else $error("back: shift lost a bit");

endmodule

@@ rtl/seven_segment_bar_serializer.sv @@
//  channel | signals                              | dir | transfer when
//  --------+--------------------------------------+-----+------------------------
//  in      | in_valid in_ready number bar_level    | in  | in_valid && in_ready
//          | dot_choice                           |     |
//  out     | out_valid out_ready serial_bit       | out | out_valid && out_ready
//          | latch_after                          |     |
//
//  Each item yields 32 output bits, one per cycle while out_ready is high, LSB
//  first; the shifter in the back end sets the sustained rate and loads the
//  next item right behind the last bit. From input transfer to the first bit
//  an item passes the 5-stage digit pipe, then the queue and shifter load.
//  Reset clears all valid flags, queue pointers and the bit counter; no sweep.
//  A stalled output holds the shifter; the digit pipe keeps accepting until the
//  queue is full and the last stage holds a word; then in_ready drops.
module seven_segment_bar_serializer import ssb_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] number,
	input  logic [7:0]  bar_level,
	input  logic [7:0]  dot_choice,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        serial_bit,
	output logic        latch_after
);

	q_status_t qstat;
	logic      push, pop;
	word_t     push_word, pop_word;

	ssb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.number    (number),
		.bar_level (bar_level),
		.dot_choice(dot_choice),
		.qstat     (qstat),
		.push      (push),
		.push_word (push_word)
	);

	ssb_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.pop      (pop),
		.pop_word (pop_word),
		.qstat    (qstat)
	);

	ssb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop        (pop),
		.pop_word   (pop_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.serial_bit (serial_bit),
		.latch_after(latch_after)
	);

endmodule
